FILE: hw/rtl/quantized_block_dequantizer_defines.svh
// Assertion helpers for the dequantizer checker.
`ifndef QUANTIZED_BLOCK_DEQUANTIZER_DEFINES_SVH
`define QUANTIZED_BLOCK_DEQUANTIZER_DEFINES_SVH

// Same-cycle implication.
`define QBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qbd same-cycle check failed");

// Next-cycle implication.
`define QBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qbd next-cycle check failed");

`endif

FILE: hw/rtl/qbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qbd_pkg;

    typedef enum logic [1:0] {
        FMT_F32  = 2'd0,
        FMT_Q8_0 = 2'd1,
        FMT_Q4_K = 2'd2,
        FMT_Q6_K = 2'd3
    } t_fmt;

    localparam logic [7:0] LEN_F32  = 8'd4;
    localparam logic [7:0] LEN_Q8_0 = 8'd34;
    localparam logic [7:0] LEN_Q4_K = 8'd144;
    localparam logic [7:0] LEN_Q6_K = 8'd210;

    localparam logic [7:0] POS_Q8_FIRST = 8'd5;
    localparam logic [7:0] POS_Q4_FIRST = 8'd19;
    localparam logic [7:0] POS_Q6_DLO   = 8'd208;
    localparam logic [7:0] POS_Q6_LAST  = 8'd209;

    typedef struct packed {
        logic       capture;
        logic [7:0] pos;
        t_fmt       fmt;
        logic       conv;
        logic       prep;
        logic       rd_hb;
        logic       mul;
        logic       f32;
        logic [1:0] lane;
        logic [5:0] ri;
        logic [7:0] cur_pos;
    } t_cmd;

    function automatic logic signed [32:0] half_to_q16(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  r;
        logic [32:0] mag;
        e = h[14:10];
        m = h[9:0];
        r = 4'd0;
        if (e == 5'd0) begin
            mag = ({23'd0, m} + 33'd128) >> 8;
        end else if (e == 5'd31) begin
            mag = 33'd1 << 30;
        end else if (e >= 5'd9) begin
            mag = {22'd0, 1'b1, m} << (e - 5'd9);
        end else begin
            r   = 4'(5'd9 - e);
            mag = ({22'd0, 1'b1, m} + (33'd1 << (r - 4'd1))) >> r;
        end
        return h[15] ? $signed(-mag) : $signed(mag);
    endfunction

    function automatic logic [63:0] single_to_q16(input logic [31:0] u);
        logic [7:0]  e;
        logic [7:0]  sh;
        logic [63:0] v;
        e  = u[30:23];
        sh = 8'd0;
        if (e == 8'd0) begin
            v = 64'd0;
        end else if (e == 8'hFF) begin
            v = 64'd1 << 30;
        end else begin
            v = {40'd0, 1'b1, u[22:0]};
            if (e >= 8'd134) begin
                sh = e - 8'd134;
                v  = (sh < 8'd64) ? (v << sh[5:0]) : 64'd0;
            end else begin
                sh = 8'd134 - e;
                v  = (sh < 8'd64) ? (v >> sh[5:0]) : 64'd0;
            end
        end
        return u[31] ? (64'd0 - v) : v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/quantized_block_dequantizer.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                   Payload
// cfg       in         i_cfg_valid / o_cfg_ready   i_cfg_block_format
// data      in         i_data_valid / o_data_ready i_data_byte
// result    out        o_res_valid / i_res_ready   index, lanes, values a..d, run_last
//
// A byte that completes no group leaves the controller idle. F32: S_F32, then S_EMIT.
// Q8_0 group: S_CONV (scale conversion), S_PREP, S_MUL per lane, S_EMIT. Q4_K group:
// S_CONV, then 2 results of S_PREP, S_MUL per lane, S_EMIT. Q6_K last byte: S_CONV, then
// 64 results; the single read port of the block store takes two reads per lane.
// Synchronous reset clears format, position and controller; the store is not cleared.
// Data and cfg ready are low from a result-causing request until its last result is taken.

module quantized_block_dequantizer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_block_format,
    input  wire logic          i_data_valid,
    output logic               o_data_ready,
    input  wire logic [7:0]    i_data_byte,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output logic [7:0]         o_first_index,
    output logic [2:0]         o_lanes_valid,
    output logic signed [63:0] o_value_a,
    output logic signed [63:0] o_value_b,
    output logic signed [63:0] o_value_c,
    output logic signed [63:0] o_value_d,
    output logic               o_run_last
);
    import qbd_pkg::*;

    t_cmd cmd;

    qbd_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_block_format (i_cfg_block_format),
        .o_cfg_ready        (o_cfg_ready),
        .i_data_valid       (i_data_valid),
        .o_data_ready       (o_data_ready),
        .o_res_valid        (o_res_valid),
        .i_res_ready        (i_res_ready),
        .o_cmd              (cmd)
    );

    qbd_datapath u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_data_byte   (i_data_byte),
        .o_first_index (o_first_index),
        .o_lanes_valid (o_lanes_valid),
        .o_value_a     (o_value_a),
        .o_value_b     (o_value_b),
        .o_value_c     (o_value_c),
        .o_value_d     (o_value_d),
        .o_run_last    (o_run_last)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/qbd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module qbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/qbd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module qbd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    input  wire logic [1:0]    i_cfg_block_format,
    output logic               o_cfg_ready,
    input  wire logic          i_data_valid,
    output logic               o_data_ready,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output qbd_pkg::t_cmd      o_cmd
);
    import qbd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CONV, S_PREP, S_RDLO, S_RDHB, S_MUL, S_F32, S_EMIT
    } t_state;

    t_state     r_state;
    t_fmt       r_fmt;
    logic [7:0] r_pos;
    logic [7:0] r_cur;
    logic [5:0] r_ri;
    logic [1:0] r_k;

    logic       data_acc;
    logic       cfg_acc;
    logic       fire;
    logic [7:0] blk_len;
    logic [7:0] n_pos;

    always_comb begin
        o_cfg_ready  = (r_state == S_IDLE);
        o_data_ready = (r_state == S_IDLE) && !i_cfg_valid;
        o_res_valid  = (r_state == S_EMIT);
        cfg_acc      = i_cfg_valid && o_cfg_ready;
        data_acc     = i_data_valid && o_data_ready;

        unique case (r_fmt)
            FMT_F32: begin
                blk_len = LEN_F32;
                fire    = (r_pos == LEN_F32 - 8'd1);
            end
            FMT_Q8_0: begin
                blk_len = LEN_Q8_0;
                fire    = (r_pos >= POS_Q8_FIRST) && (r_pos[1:0] == 2'b01);
            end
            FMT_Q4_K: begin
                blk_len = LEN_Q4_K;
                fire    = (r_pos >= POS_Q4_FIRST) && (r_pos[1:0] == 2'b11);
            end
            FMT_Q6_K: begin
                blk_len = LEN_Q6_K;
                fire    = (r_pos == POS_Q6_LAST);
            end
            default: begin
                blk_len = LEN_F32;
                fire    = 1'b0;
            end
        endcase
        n_pos = (r_pos == blk_len - 8'd1) ? 8'd0 : r_pos + 8'd1;

        o_cmd.capture = data_acc;
        o_cmd.pos     = r_pos;
        o_cmd.fmt     = r_fmt;
        o_cmd.conv    = (r_state == S_CONV);
        o_cmd.prep    = (r_state == S_PREP);
        o_cmd.rd_hb   = (r_state == S_RDHB);
        o_cmd.mul     = (r_state == S_MUL);
        o_cmd.f32     = (r_state == S_F32);
        o_cmd.lane    = r_k;
        o_cmd.ri      = r_ri;
        o_cmd.cur_pos = r_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fmt   <= FMT_F32;
            r_pos   <= 8'd0;
            r_cur   <= 8'd0;
            r_ri    <= 6'd0;
            r_k     <= 2'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (cfg_acc) begin
                        r_fmt <= t_fmt'(i_cfg_block_format);
                        r_pos <= 8'd0;
                    end else if (data_acc) begin
                        r_pos <= n_pos;
                        r_cur <= r_pos;
                        r_ri  <= 6'd0;
                        r_k   <= 2'd0;
                        if (fire) begin
                            r_state <= (r_fmt == FMT_F32) ? S_F32 : S_CONV;
                        end
                    end
                end
                S_CONV: r_state <= S_PREP;
                S_PREP: begin
                    r_k     <= 2'd0;
                    r_state <= (r_fmt == FMT_Q6_K) ? S_RDLO : S_MUL;
                end
                S_RDLO: r_state <= S_RDHB;
                S_RDHB: r_state <= S_MUL;
                S_MUL: begin
                    if (r_k == 2'd3) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= (r_fmt == FMT_Q6_K) ? S_RDLO : S_MUL;
                    end
                end
                S_F32: r_state <= S_EMIT;
                S_EMIT: begin
                    if (i_res_ready) begin
                        if (r_fmt == FMT_Q4_K && r_ri == 6'd0) begin
                            r_ri    <= 6'd1;
                            r_state <= S_PREP;
                        end else if (r_fmt == FMT_Q6_K && !(&r_ri)) begin
                            r_ri    <= r_ri + 6'd1;
                            r_state <= S_PREP;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/qbd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module qbd_datapath (
    input  wire logic          i_clk,
    input  wire qbd_pkg::t_cmd i_cmd,
    input  wire logic [7:0]    i_data_byte,
    output logic [7:0]         o_first_index,
    output logic [2:0]         o_lanes_valid,
    output logic signed [63:0] o_value_a,
    output logic signed [63:0] o_value_b,
    output logic signed [63:0] o_value_c,
    output logic signed [63:0] o_value_d,
    output logic               o_run_last
);
    import qbd_pkg::*;

    logic [7:0]         r_sh [4];
    logic [15:0]        r_h0;
    logic [15:0]        r_h1;
    logic [7:0]         r_qs [12];
    logic [7:0]         r_sc6 [16];
    logic signed [32:0] r_dq;
    logic signed [32:0] r_dmq;
    logic signed [40:0] r_p1;
    logic signed [39:0] r_pm;
    logic [7:0]         r_lo;
    logic [63:0]        r_val [4];
    logic [7:0]         r_first;
    logic [2:0]         r_lanes;
    logic               r_last;

    logic [7:0]         ram_rdata;
    logic [7:0]         ram_raddr;
    logic [7:0]         f6;
    logic [7:0]         rel;
    logic [2:0]         j;
    logic [5:0]         sc4;
    logic [5:0]         mn4;
    logic [7:0]         sc6;
    logic [1:0]         quarter;
    logic [3:0]         nib6;
    logic [1:0]         hb2;
    logic [5:0]         v6;
    logic [7:0]         lb;
    logic signed [8:0]  q;
    logic signed [49:0] prod;
    logic signed [49:0] res;

    qbd_ram #(.WIDTH(8), .DEPTH(256)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.capture),
        .i_waddr (i_cmd.pos),
        .i_wdata (i_data_byte),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        f6        = {i_cmd.ri, i_cmd.lane};
        ram_raddr = i_cmd.rd_hb ? {2'b10, f6[7], f6[4:0]} : {1'b0, f6[7], f6[5], f6[4:0]};
        rel       = i_cmd.cur_pos - POS_Q4_FIRST;
        j         = {rel[6:5], i_cmd.ri[0]};
        if (!j[2]) begin
            sc4 = r_qs[{2'b00, j[1:0]}][5:0];
            mn4 = r_qs[{2'b01, j[1:0]}][5:0];
        end else begin
            sc4 = {r_qs[{2'b00, j[1:0]}][7:6], r_qs[{2'b10, j[1:0]}][3:0]};
            mn4 = {r_qs[{2'b01, j[1:0]}][7:6], r_qs[{2'b10, j[1:0]}][7:4]};
        end
        sc6     = r_sc6[{i_cmd.ri[5], i_cmd.ri[4:3], i_cmd.ri[2]}];
        quarter = i_cmd.ri[4:3];
        nib6    = quarter[1] ? r_lo[7:4] : r_lo[3:0];
        case (quarter)
            2'd0:    hb2 = ram_rdata[1:0];
            2'd1:    hb2 = ram_rdata[3:2];
            2'd2:    hb2 = ram_rdata[5:4];
            default: hb2 = ram_rdata[7:6];
        endcase
        v6 = {hb2, nib6};
        lb = r_sh[i_cmd.lane];
        unique case (i_cmd.fmt)
            FMT_Q8_0: q = {lb[7], lb};
            FMT_Q4_K: q = i_cmd.ri[0] ? {5'd0, lb[7:4]} : {5'd0, lb[3:0]};
            FMT_Q6_K: q = {{3{~v6[5]}}, ~v6[5], v6[4:0]};
            default:  q = 9'sd0;
        endcase
        prod = r_p1 * q;
        res  = prod - $signed({{10{r_pm[39]}}, r_pm});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sh[0] <= r_sh[1];
            r_sh[1] <= r_sh[2];
            r_sh[2] <= r_sh[3];
            r_sh[3] <= i_data_byte;
            if (i_cmd.pos == 8'd0 || i_cmd.pos == POS_Q6_DLO) r_h0[7:0] <= i_data_byte;
            if (i_cmd.pos == 8'd1 || i_cmd.pos == POS_Q6_LAST) r_h0[15:8] <= i_data_byte;
            if (i_cmd.pos == 8'd2) r_h1[7:0] <= i_data_byte;
            if (i_cmd.pos == 8'd3) r_h1[15:8] <= i_data_byte;
            if (i_cmd.pos >= 8'd4 && i_cmd.pos < 8'd16) begin
                r_qs[4'(i_cmd.pos - 8'd4)] <= i_data_byte;
            end
            if (i_cmd.pos[7:4] == 4'hC) r_sc6[i_cmd.pos[3:0]] <= i_data_byte;
        end
        if (i_cmd.conv) begin
            r_dq  <= half_to_q16(r_h0);
            r_dmq <= half_to_q16(r_h1);
        end
        if (i_cmd.prep) begin
            r_lanes <= 3'd4;
            unique case (i_cmd.fmt)
                FMT_Q8_0: begin
                    r_p1    <= {{8{r_dq[32]}}, r_dq};
                    r_pm    <= 40'sd0;
                    r_first <= i_cmd.cur_pos - POS_Q8_FIRST;
                    r_last  <= 1'b1;
                end
                FMT_Q4_K: begin
                    r_p1    <= r_dq * $signed({1'b0, sc4});
                    r_pm    <= r_dmq * $signed({1'b0, mn4});
                    r_first <= {rel[6:5], i_cmd.ri[0], rel[4:0]};
                    r_last  <= i_cmd.ri[0];
                end
                default: begin
                    r_p1    <= r_dq * $signed(sc6);
                    r_pm    <= 40'sd0;
                    r_first <= {i_cmd.ri, 2'b00};
                    r_last  <= &i_cmd.ri;
                end
            endcase
        end
        if (i_cmd.rd_hb) r_lo <= ram_rdata;
        if (i_cmd.mul) r_val[i_cmd.lane] <= {{14{res[49]}}, res};
        if (i_cmd.f32) begin
            r_val[0] <= single_to_q16({r_sh[3], r_sh[2], r_sh[1], r_sh[0]});
            r_val[1] <= 64'd0;
            r_val[2] <= 64'd0;
            r_val[3] <= 64'd0;
            r_first  <= 8'd0;
            r_lanes  <= 3'd1;
            r_last   <= 1'b1;
        end
    end

    assign o_first_index = r_first;
    assign o_lanes_valid = r_lanes;
    assign o_value_a     = $signed(r_val[0]);
    assign o_value_b     = $signed(r_val[1]);
    assign o_value_c     = $signed(r_val[2]);
    assign o_value_d     = $signed(r_val[3]);
    assign o_run_last    = r_last;

endmodule

`default_nettype wire

FILE: hw/rtl/qbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "quantized_block_dequantizer_defines.svh"

module qbd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_cfg_ready,
    input wire logic        o_data_ready,
    input wire logic        o_res_valid,
    input wire logic        i_res_ready,
    input wire logic [7:0]  o_first_index,
    input wire logic [2:0]  o_lanes_valid,
    input wire logic [63:0] o_value_a,
    input wire logic [63:0] o_value_b,
    input wire logic        o_run_last
);

    `QBD_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_res_valid && !i_res_ready, o_res_valid && $stable(o_value_a) && $stable(o_first_index))
    `QBD_ASSERT_SAME(a_busy_while_result, i_clk, i_rst_n, o_res_valid, !o_data_ready && !o_cfg_ready)
    `QBD_ASSERT_SAME(a_f32_shape, i_clk, i_rst_n, o_res_valid && o_lanes_valid == 3'd1, o_run_last && o_first_index == 8'd0 && o_value_b == 64'd0)
    `QBD_ASSERT_NEXT(a_more_pending, i_clk, i_rst_n, o_res_valid && i_res_ready && !o_run_last, !o_data_ready)

endmodule

bind quantized_block_dequantizer qbd_checker u_qbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_cfg_ready   (o_cfg_ready),
    .o_data_ready  (o_data_ready),
    .o_res_valid   (o_res_valid),
    .i_res_ready   (i_res_ready),
    .o_first_index (o_first_index),
    .o_lanes_valid (o_lanes_valid),
    .o_value_a     (o_value_a),
    .o_value_b     (o_value_b),
    .o_run_last    (o_run_last)
);

`default_nettype wire

FILE: bench/quantized_block_dequantizer_test.sv
`timescale 1ns / 1ps

module quantized_block_dequantizer_test;
    import qbd_pkg::*;

    typedef struct packed {
        logic [7:0]  first;
        logic [2:0]  lanes;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        logic        last;
    } t_vals;

    typedef struct packed {
        logic        is_cfg;
        logic [7:0]  val;
        logic        typed;
        logic [63:0] want;
    } t_row;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_block_format = 2'd0;
    logic        i_data_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_res_ready = 1'b0;
    logic        o_cfg_ready, o_data_ready, o_res_valid, o_run_last;
    logic [7:0]  o_first_index;
    logic [2:0]  o_lanes_valid;
    logic signed [63:0] o_value_a, o_value_b, o_value_c, o_value_d;

    quantized_block_dequantizer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_block_format(i_cfg_block_format),
        .i_data_valid(i_data_valid), .o_data_ready(o_data_ready),
        .i_data_byte(i_data_byte),
        .o_res_valid(o_res_valid), .i_res_ready(i_res_ready),
        .o_first_index(o_first_index), .o_lanes_valid(o_lanes_valid),
        .o_value_a(o_value_a), .o_value_b(o_value_b),
        .o_value_c(o_value_c), .o_value_d(o_value_d),
        .o_run_last(o_run_last)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [7:0] blk_mem [256];
    logic [7:0] blk_pos = 8'd0;
    t_fmt       cur_fmt = FMT_F32;

    t_vals expected_vals[$];
    int    mismatches = 0;
    int    bytes_sent = 0;
    int    vals_seen = 0;
    int    cfg_writes = 0;
    int    idle_cycles = 0;
    bit    calm = 1'b0;
    int    res_stall = 0;

    function automatic longint half_q16(logic [15:0] h);
        longint w;
        int     ex, r;
        ex = h[14:10];
        if (ex == 0) begin
            w = (longint'(h[9:0]) + 128) >>> 8;
        end else if (ex == 31) begin
            w = longint'(1) << 30;
        end else begin
            w = 1024 + longint'(h[9:0]);
            if (ex >= 9) begin
                w = w << (ex - 9);
            end else begin
                r = 9 - ex;
                w = (w + (longint'(1) << (r - 1))) >>> r;
            end
        end
        return h[15] ? -w : w;
    endfunction

    function automatic logic [63:0] single_q16(logic [31:0] u);
        logic [63:0] v;
        int          sh;
        if (u[30:23] == 8'd0) return 64'd0;
        if (u[30:23] == 8'hFF) begin
            v = 64'd1 << 30;
        end else begin
            v = {40'd0, 1'b1, u[22:0]};
            sh = int'(u[30:23]) - 134;
            if (sh >= 0) v = (sh < 64) ? (v << sh) : 64'd0;
            else v = (-sh < 64) ? (v >> (-sh)) : 64'd0;
        end
        return u[31] ? (64'd0 - v) : v;
    endfunction

    function automatic longint q4k_weight(int idx, longint dd, longint dm);
        int     g, hi, l, j;
        longint nib, sc, mn;
        logic [7:0] qb;
        g  = (idx >> 6) & 3;
        hi = (idx >> 5) & 1;
        l  = idx & 31;
        qb = blk_mem[16 + 32 * g + l];
        nib = hi ? longint'(qb[7:4]) : longint'(qb[3:0]);
        j = 2 * g + hi;
        if (j < 4) begin
            sc = blk_mem[4 + j] & 63;
            mn = blk_mem[8 + j] & 63;
        end else begin
            sc = (blk_mem[8 + j] & 15) | ((blk_mem[j] >> 6) << 4);
            mn = (blk_mem[8 + j] >> 4) | ((blk_mem[4 + j] >> 6) << 4);
        end
        return dd * sc * nib - dm * mn;
    endfunction

    function automatic longint q6k_weight(int idx, longint dd);
        int     h, qt, l;
        longint nib, q, sc;
        logic [7:0] lo, hb;
        h  = (idx >> 7) & 1;
        qt = (idx >> 5) & 3;
        l  = idx & 31;
        lo = blk_mem[64 * h + l + (qt & 1) * 32];
        hb = blk_mem[128 + 32 * h + l];
        nib = (qt >= 2) ? longint'(lo[7:4]) : longint'(lo[3:0]);
        q  = (nib | (longint'((hb >> (2 * qt)) & 8'd3) << 4)) - 32;
        sc = longint'($signed(blk_mem[192 + 8 * h + l / 16 + 2 * qt]));
        return dd * sc * q;
    endfunction

    function automatic int fmt_len(t_fmt f);
        case (f)
            FMT_F32:  return int'(LEN_F32);
            FMT_Q8_0: return int'(LEN_Q8_0);
            FMT_Q4_K: return int'(LEN_Q4_K);
            default:  return int'(LEN_Q6_K);
        endcase
    endfunction

    task automatic dequant_byte(input logic [7:0] b, ref t_vals rq[$]);
        t_vals  r;
        longint dd, dm;
        int     p, base, f;
        p = blk_pos;
        blk_mem[p] = b;
        case (cur_fmt)
            FMT_F32: begin
                if (p == 3) begin
                    r = '0;
                    r.lanes = 3'd1;
                    r.a = single_q16({blk_mem[3], blk_mem[2], blk_mem[1], blk_mem[0]});
                    rq.push_back(r);
                end
            end
            FMT_Q8_0: begin
                if (p >= 5 && ((p - 2) & 3) == 3) begin
                    dd = half_q16({blk_mem[1], blk_mem[0]});
                    r = '0;
                    r.first = 8'(p - 5);
                    r.lanes = 3'd4;
                    r.a = dd * longint'($signed(blk_mem[p - 3]));
                    r.b = dd * longint'($signed(blk_mem[p - 2]));
                    r.c = dd * longint'($signed(blk_mem[p - 1]));
                    r.d = dd * longint'($signed(blk_mem[p]));
                    rq.push_back(r);
                end
            end
            FMT_Q4_K: begin
                if (p >= 19 && ((p - 16) & 3) == 3) begin
                    base = 64 * (((p - 19) >> 5) & 3) + ((p - 19) & 31);
                    dd = half_q16({blk_mem[1], blk_mem[0]});
                    dm = half_q16({blk_mem[3], blk_mem[2]});
                    for (int i = 0; i < 2; i++) begin
                        f = base + 32 * i;
                        r = '0;
                        r.first = 8'(f);
                        r.lanes = 3'd4;
                        r.a = q4k_weight(f, dd, dm);
                        r.b = q4k_weight(f + 1, dd, dm);
                        r.c = q4k_weight(f + 2, dd, dm);
                        r.d = q4k_weight(f + 3, dd, dm);
                        rq.push_back(r);
                    end
                end
            end
            default: begin
                if (p == int'(POS_Q6_LAST)) begin
                    dd = half_q16({blk_mem[209], blk_mem[208]});
                    for (int i = 0; i < 64; i++) begin
                        r = '0;
                        r.first = 8'(4 * i);
                        r.lanes = 3'd4;
                        r.a = q6k_weight(4 * i, dd);
                        r.b = q6k_weight(4 * i + 1, dd);
                        r.c = q6k_weight(4 * i + 2, dd);
                        r.d = q6k_weight(4 * i + 3, dd);
                        rq.push_back(r);
                    end
                end
            end
        endcase
        if (rq.size() > 0) rq[rq.size() - 1].last = 1'b1;
        p++;
        if (p >= fmt_len(cur_fmt)) p = 0;
        blk_pos = 8'(p);
    endtask

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_byte(input logic [7:0] b, input logic typed, input logic [63:0] want);
        t_vals rq[$];
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_data_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_data_valid <= 1'b1;
        i_data_byte  <= b;
        do @(posedge i_clk); while (!o_data_ready);
        dequant_byte(b, rq);
        bytes_sent++;
        if (typed && rq.size() == 1) begin
            rq[0].a = want;
        end
        foreach (rq[k]) expected_vals.push_back(rq[k]);
        @(negedge i_clk);
    endtask

    task automatic write_format(input t_fmt f);
        i_data_valid <= 1'b0;
        while (expected_vals.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_block_format <= f;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_fmt = f;
        blk_pos = 8'd0;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    always @(negedge i_clk) begin
        if (calm) begin
            i_res_ready <= 1'b1;
        end else if (res_stall > 0) begin
            res_stall   <= res_stall - 1;
            i_res_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            res_stall   <= $urandom_range(0, 2);
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_vals e;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            vals_seen++;
            if (expected_vals.size() == 0) begin
                report("unexpected request", o_first_index, 64'd0);
            end else begin
                e = expected_vals.pop_front();
                if (o_first_index != e.first) report("first_index", o_first_index, e.first);
                if (o_lanes_valid != e.lanes) report("lanes_valid", o_lanes_valid, e.lanes);
                if (o_value_a != e.a) report("value_a", o_value_a, e.a);
                if (o_value_b != e.b) report("value_b", o_value_b, e.b);
                if (o_value_c != e.c) report("value_c", o_value_c, e.c);
                if (o_value_d != e.d) report("value_d", o_value_d, e.d);
                if (o_run_last != e.last) report("run_last", o_run_last, e.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_data_valid && o_data_ready) || (i_cfg_valid && o_cfg_ready)
                || (o_res_valid && i_res_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d requests outstanding", expected_vals.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    t_row dir_rows[] = '{
        '{1'b0, 8'h00, 1'b0, 64'd0}, '{1'b0, 8'h00, 1'b0, 64'd0},
        '{1'b0, 8'h80, 1'b0, 64'd0}, '{1'b0, 8'h3F, 1'b1, 64'd65536},
        '{1'b0, 8'h00, 1'b0, 64'd0}, '{1'b0, 8'h00, 1'b0, 64'd0},
        '{1'b0, 8'h80, 1'b0, 64'd0}, '{1'b0, 8'hFF, 1'b1, 64'hFFFF_FFFF_C000_0000},
        '{1'b0, 8'h01, 1'b0, 64'd0}, '{1'b0, 8'h00, 1'b0, 64'd0},
        '{1'b0, 8'h00, 1'b0, 64'd0}, '{1'b0, 8'h00, 1'b1, 64'd0},
        '{1'b0, 8'hFF, 1'b0, 64'd0}, '{1'b0, 8'hFF, 1'b0, 64'd0},
        '{1'b0, 8'h7F, 1'b0, 64'd0}, '{1'b0, 8'h7F, 1'b1, 64'd0},
        '{1'b1, 8'd1,  1'b0, 64'd0},
        '{1'b0, 8'h00, 1'b0, 64'd0}, '{1'b0, 8'h7C, 1'b0, 64'd0},
        '{1'b0, 8'h80, 1'b0, 64'd0}, '{1'b0, 8'h7F, 1'b0, 64'd0},
        '{1'b0, 8'h01, 1'b0, 64'd0}, '{1'b0, 8'hFF, 1'b0, 64'd0},
        '{1'b0, 8'h05, 1'b0, 64'd0},
        '{1'b1, 8'd2,  1'b0, 64'd0}
    };

    initial begin
        t_fmt f;
        int   nb;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) write_format(t_fmt'(dir_rows[k].val[1:0]));
            else send_byte(dir_rows[k].val, dir_rows[k].typed, dir_rows[k].want);
        end

        // Q6_K with extreme and subnormal scale bytes, then short random runs
        write_format(FMT_Q6_K);
        for (int n = 0; n < 210; n++) begin
            send_byte((n == 208) ? 8'hFF : (n == 209) ? 8'h03 : 8'($urandom), 1'b0, 64'd0);
        end
        for (int ph = 0; ph < 4; ph++) begin
            calm = (ph == 3);
            f = (ph < 3) ? t_fmt'(ph[1:0]) : t_fmt'($urandom_range(0, 2));
            write_format(f);
            case (f)
                FMT_F32:  nb = fmt_len(f) * $urandom_range(2, 4);
                FMT_Q8_0: nb = fmt_len(f);
                default:  nb = $urandom_range(24, 40);
            endcase
            if (f != FMT_Q4_K && $urandom_range(0, 3) == 0) begin
                nb = nb + $urandom_range(1, fmt_len(f) - 1);
            end
            for (int n = 0; n < nb; n++) begin
                send_byte(8'($urandom), 1'b0, 64'd0);
            end
        end
        i_data_valid <= 1'b0;

        while (expected_vals.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        $display("covered %0d bytes, %0d format writes, %0d value groups checked",
                 bytes_sent, cfg_writes, vals_seen);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/qbd_pkg.sv
hw/rtl/qbd_ram.sv
hw/rtl/qbd_ctrl.sv
hw/rtl/qbd_datapath.sv
hw/rtl/quantized_block_dequantizer.sv
hw/rtl/qbd_checker.sv
bench/quantized_block_dequantizer_test.sv
